>>> src/cau_pkg.sv
package cau_pkg;

   localparam int DATA_WIDTH = 16;
   localparam int FRAC_BITS  = 8;
   localparam int CMD_WIDTH  = 3;

   localparam logic [CMD_WIDTH-1:0] CMD_ADD  = 3'd0;
   localparam logic [CMD_WIDTH-1:0] CMD_SUB  = 3'd1;
   localparam logic [CMD_WIDTH-1:0] CMD_MUL  = 3'd2;
   localparam logic [CMD_WIDTH-1:0] CMD_DIV  = 3'd3;
   localparam logic [CMD_WIDTH-1:0] CMD_CONJ = 3'd4;

   typedef struct packed {
      logic valid;
      logic is_div;
      logic dz;
      logic eq;
   } ctrl_type;

endpackage

>>> src/complex_arithmetic_unit_core.sv
// Complex arithmetic unit: add, subtract, multiply, divide and conjugate on
// signed fixed-point complex operands, with equality, divide-by-zero and
// saturation flags.
// A request transfer takes place at a rising edge with start high and busy
// low; busy is high only while reset is asserted, so one request can be
// transferred in every cycle.
// Each result appears on the rsp_ ports for exactly one cycle, marked by
// rsp_valid, after the request has passed the multiply, sum and overflow
// check stages, the divider and the saturation stage. The divider resolves one
// quotient bit per pipeline stage; multiply, sum, overflow check and
// saturation take one stage each. All operations share the same pipeline,
// so results leave in request order at one per cycle.
// The receiver cannot stall, so results are never held back.
// Reset clears every valid bit; items in flight at reset are dropped.
module complex_arithmetic_unit_core #(
   parameter int DATA_WIDTH = cau_pkg::DATA_WIDTH,
   parameter int FRAC_BITS  = cau_pkg::FRAC_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [cau_pkg::CMD_WIDTH-1:0] req_cmd,
   input  logic signed [DATA_WIDTH-1:0]  req_a_re,
   input  logic signed [DATA_WIDTH-1:0]  req_a_im,
   input  logic signed [DATA_WIDTH-1:0]  req_b_re,
   input  logic signed [DATA_WIDTH-1:0]  req_b_im,
   output logic                          rsp_valid,
   output logic signed [DATA_WIDTH-1:0]  rsp_res_re,
   output logic signed [DATA_WIDTH-1:0]  rsp_res_im,
   output logic                          rsp_is_equal,
   output logic                          rsp_div_zero,
   output logic                          rsp_sat_flag
);

   localparam int DW  = DATA_WIDTH;
   localparam int F   = FRAC_BITS;
   localparam int MW  = 2 * DW + 1;
   localparam int NW  = MW + F;
   localparam int WW  = MW + F + DW;
   localparam int LAT = DW + 4;
   localparam logic [DW-1:0] MAXV = {1'b0, {(DW - 1){1'b1}}};
   localparam logic [DW-1:0] MINV = {1'b1, {(DW - 1){1'b0}}};

   logic accept;

   cau_pkg::ctrl_type             m_ctrl;
   logic [cau_pkg::CMD_WIDTH-1:0] m_cmd;
   logic signed [DW-1:0]          m_a_re, m_a_im, m_b_re, m_b_im;
   logic signed [2*DW-1:0]        m_p_rr, m_p_ii, m_p_ri, m_p_ir, m_p_bb_r, m_p_bb_i;

   cau_pkg::ctrl_type s_ctrl;
   logic              s_neg_re, s_neg_im;
   logic [MW-1:0]     s_mag_re, s_mag_im, s_den;

   cau_pkg::ctrl_type c_ctrl_ff;
   logic              c_neg_re_ff, c_neg_im_ff, c_ovf_re_ff, c_ovf_im_ff;
   logic              c_ovf_re_in, c_ovf_im_in;
   logic [MW-1:0]     c_den_ff;
   logic [NW-1:0]     c_rem_re_ff, c_rem_im_ff, c_rem_re_in, c_rem_im_in;
   logic [WW-1:0]     c_dlim;

   cau_pkg::ctrl_type d_ctrl   [DW+1];
   logic              d_neg_re [DW+1];
   logic              d_neg_im [DW+1];
   logic              d_ovf_re [DW+1];
   logic              d_ovf_im [DW+1];
   logic [MW-1:0]     d_den    [DW+1];
   logic [NW-1:0]     d_rem_re [DW+1];
   logic [NW-1:0]     d_rem_im [DW+1];
   logic [DW-1:0]     d_q_re   [DW+1];
   logic [DW-1:0]     d_q_im   [DW+1];

   assign busy   = reset;
   assign accept = start && !busy;

   cau_mult #(
      .DW(DW)
   ) u_mult (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (accept),
      .in_cmd     (req_cmd),
      .in_a_re    (req_a_re),
      .in_a_im    (req_a_im),
      .in_b_re    (req_b_re),
      .in_b_im    (req_b_im),
      .out_ctrl   (m_ctrl),
      .out_cmd    (m_cmd),
      .out_a_re   (m_a_re),
      .out_a_im   (m_a_im),
      .out_b_re   (m_b_re),
      .out_b_im   (m_b_im),
      .out_p_rr   (m_p_rr),
      .out_p_ii   (m_p_ii),
      .out_p_ri   (m_p_ri),
      .out_p_ir   (m_p_ir),
      .out_p_bb_r (m_p_bb_r),
      .out_p_bb_i (m_p_bb_i)
   );

   cau_sum #(
      .DW(DW),
      .F (F)
   ) u_sum (
      .clock      (clock),
      .reset      (reset),
      .in_ctrl    (m_ctrl),
      .in_cmd     (m_cmd),
      .in_a_re    (m_a_re),
      .in_a_im    (m_a_im),
      .in_b_re    (m_b_re),
      .in_b_im    (m_b_im),
      .in_p_rr    (m_p_rr),
      .in_p_ii    (m_p_ii),
      .in_p_ri    (m_p_ri),
      .in_p_ir    (m_p_ir),
      .in_p_bb_r  (m_p_bb_r),
      .in_p_bb_i  (m_p_bb_i),
      .out_ctrl   (s_ctrl),
      .out_neg_re (s_neg_re),
      .out_neg_im (s_neg_im),
      .out_mag_re (s_mag_re),
      .out_mag_im (s_mag_im),
      .out_den    (s_den)
   );

   always_comb begin
      c_rem_re_in = s_ctrl.is_div ? (NW'(s_mag_re) << F) : NW'(s_mag_re);
      c_rem_im_in = s_ctrl.is_div ? (NW'(s_mag_im) << F) : NW'(s_mag_im);
      c_dlim      = WW'(s_den) << DW;
      c_ovf_re_in = WW'(c_rem_re_in) >= c_dlim;
      c_ovf_im_in = WW'(c_rem_im_in) >= c_dlim;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_ctrl_ff.valid <= 1'b0;
      end else begin
         c_ctrl_ff.valid <= s_ctrl.valid;
      end
      c_ctrl_ff.is_div <= s_ctrl.is_div;
      c_ctrl_ff.dz     <= s_ctrl.dz;
      c_ctrl_ff.eq     <= s_ctrl.eq;
      c_neg_re_ff      <= s_neg_re;
      c_neg_im_ff      <= s_neg_im;
      c_ovf_re_ff      <= c_ovf_re_in;
      c_ovf_im_ff      <= c_ovf_im_in;
      c_den_ff         <= s_den;
      c_rem_re_ff      <= c_rem_re_in;
      c_rem_im_ff      <= c_rem_im_in;
   end

   assign d_ctrl[0]   = c_ctrl_ff;
   assign d_neg_re[0] = c_neg_re_ff;
   assign d_neg_im[0] = c_neg_im_ff;
   assign d_ovf_re[0] = c_ovf_re_ff;
   assign d_ovf_im[0] = c_ovf_im_ff;
   assign d_den[0]    = c_den_ff;
   assign d_rem_re[0] = c_rem_re_ff;
   assign d_rem_im[0] = c_rem_im_ff;
   assign d_q_re[0]   = '0;
   assign d_q_im[0]   = '0;

   for (genvar i = 0; i < DW; i++) begin : g_div
      cau_div_step #(
         .DW (DW),
         .F  (F),
         .BIT(DW - 1 - i)
      ) u_step (
         .clock      (clock),
         .reset      (reset),
         .in_ctrl    (d_ctrl[i]),
         .in_neg_re  (d_neg_re[i]),
         .in_neg_im  (d_neg_im[i]),
         .in_ovf_re  (d_ovf_re[i]),
         .in_ovf_im  (d_ovf_im[i]),
         .in_den     (d_den[i]),
         .in_rem_re  (d_rem_re[i]),
         .in_rem_im  (d_rem_im[i]),
         .in_q_re    (d_q_re[i]),
         .in_q_im    (d_q_im[i]),
         .out_ctrl   (d_ctrl[i+1]),
         .out_neg_re (d_neg_re[i+1]),
         .out_neg_im (d_neg_im[i+1]),
         .out_ovf_re (d_ovf_re[i+1]),
         .out_ovf_im (d_ovf_im[i+1]),
         .out_den    (d_den[i+1]),
         .out_rem_re (d_rem_re[i+1]),
         .out_rem_im (d_rem_im[i+1]),
         .out_q_re   (d_q_re[i+1]),
         .out_q_im   (d_q_im[i+1])
      );
   end

   cau_sat #(
      .DW(DW),
      .F (F)
   ) u_sat (
      .clock        (clock),
      .reset        (reset),
      .in_ctrl      (d_ctrl[DW]),
      .in_neg_re    (d_neg_re[DW]),
      .in_neg_im    (d_neg_im[DW]),
      .in_ovf_re    (d_ovf_re[DW]),
      .in_ovf_im    (d_ovf_im[DW]),
      .in_rem_re    (d_rem_re[DW]),
      .in_rem_im    (d_rem_im[DW]),
      .in_q_re      (d_q_re[DW]),
      .in_q_im      (d_q_im[DW]),
      .out_valid    (rsp_valid),
      .out_res_re   (rsp_res_re),
      .out_res_im   (rsp_res_im),
      .out_is_equal (rsp_is_equal),
      .out_div_zero (rsp_div_zero),
      .out_sat_flag (rsp_sat_flag)
   );

   a_latency: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##LAT rsp_valid)
      else $error("request transfer did not produce a result on time");

   a_flags_gated: assert property (@(posedge clock)
      !rsp_valid |-> !rsp_is_equal && !rsp_div_zero && !rsp_sat_flag)
      else $error("result flag raised without a result strobe");

   a_div_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_div_zero |-> (rsp_res_re == '0) && (rsp_res_im == '0) && !rsp_sat_flag)
      else $error("divide by zero gave a nonzero or saturated result");

   a_sat_extreme: assert property (@(posedge clock) disable iff (reset)
      rsp_sat_flag |-> (rsp_res_re == MAXV) || (rsp_res_re == MINV) ||
                       (rsp_res_im == MAXV) || (rsp_res_im == MINV))
      else $error("saturation flagged but no part is at a limit");

endmodule

>>> src/cau_mult.sv
module cau_mult #(
   parameter int DW = cau_pkg::DATA_WIDTH
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   input  logic [cau_pkg::CMD_WIDTH-1:0] in_cmd,
   input  logic signed [DW-1:0]          in_a_re,
   input  logic signed [DW-1:0]          in_a_im,
   input  logic signed [DW-1:0]          in_b_re,
   input  logic signed [DW-1:0]          in_b_im,
   output cau_pkg::ctrl_type             out_ctrl,
   output logic [cau_pkg::CMD_WIDTH-1:0] out_cmd,
   output logic signed [DW-1:0]          out_a_re,
   output logic signed [DW-1:0]          out_a_im,
   output logic signed [DW-1:0]          out_b_re,
   output logic signed [DW-1:0]          out_b_im,
   output logic signed [2*DW-1:0]        out_p_rr,
   output logic signed [2*DW-1:0]        out_p_ii,
   output logic signed [2*DW-1:0]        out_p_ri,
   output logic signed [2*DW-1:0]        out_p_ir,
   output logic signed [2*DW-1:0]        out_p_bb_r,
   output logic signed [2*DW-1:0]        out_p_bb_i
);

   cau_pkg::ctrl_type             ctrl_ff;
   cau_pkg::ctrl_type             ctrl_in;
   logic [cau_pkg::CMD_WIDTH-1:0] cmd_ff;
   logic signed [DW-1:0]          a_re_ff, a_im_ff, b_re_ff, b_im_ff;
   logic signed [2*DW-1:0]        p_rr_ff, p_ii_ff, p_ri_ff, p_ir_ff, p_bb_r_ff, p_bb_i_ff;

   always_comb begin
      ctrl_in.valid  = in_valid;
      ctrl_in.is_div = (in_cmd == cau_pkg::CMD_DIV);
      ctrl_in.dz     = (in_cmd == cau_pkg::CMD_DIV) && (in_b_re == '0) && (in_b_im == '0);
      ctrl_in.eq     = (in_a_re == in_b_re) && (in_a_im == in_b_im);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff.valid <= 1'b0;
      end else begin
         ctrl_ff.valid <= ctrl_in.valid;
      end
      ctrl_ff.is_div <= ctrl_in.is_div;
      ctrl_ff.dz     <= ctrl_in.dz;
      ctrl_ff.eq     <= ctrl_in.eq;
      cmd_ff         <= in_cmd;
      a_re_ff        <= in_a_re;
      a_im_ff        <= in_a_im;
      b_re_ff        <= in_b_re;
      b_im_ff        <= in_b_im;
      p_rr_ff        <= in_a_re * in_b_re;
      p_ii_ff        <= in_a_im * in_b_im;
      p_ri_ff        <= in_a_re * in_b_im;
      p_ir_ff        <= in_a_im * in_b_re;
      p_bb_r_ff      <= in_b_re * in_b_re;
      p_bb_i_ff      <= in_b_im * in_b_im;
   end

   assign out_ctrl   = ctrl_ff;
   assign out_cmd    = cmd_ff;
   assign out_a_re   = a_re_ff;
   assign out_a_im   = a_im_ff;
   assign out_b_re   = b_re_ff;
   assign out_b_im   = b_im_ff;
   assign out_p_rr   = p_rr_ff;
   assign out_p_ii   = p_ii_ff;
   assign out_p_ri   = p_ri_ff;
   assign out_p_ir   = p_ir_ff;
   assign out_p_bb_r = p_bb_r_ff;
   assign out_p_bb_i = p_bb_i_ff;

endmodule

>>> src/cau_sum.sv
module cau_sum #(
   parameter int DW = cau_pkg::DATA_WIDTH,
   parameter int F  = cau_pkg::FRAC_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  cau_pkg::ctrl_type             in_ctrl,
   input  logic [cau_pkg::CMD_WIDTH-1:0] in_cmd,
   input  logic signed [DW-1:0]          in_a_re,
   input  logic signed [DW-1:0]          in_a_im,
   input  logic signed [DW-1:0]          in_b_re,
   input  logic signed [DW-1:0]          in_b_im,
   input  logic signed [2*DW-1:0]        in_p_rr,
   input  logic signed [2*DW-1:0]        in_p_ii,
   input  logic signed [2*DW-1:0]        in_p_ri,
   input  logic signed [2*DW-1:0]        in_p_ir,
   input  logic signed [2*DW-1:0]        in_p_bb_r,
   input  logic signed [2*DW-1:0]        in_p_bb_i,
   output cau_pkg::ctrl_type             out_ctrl,
   output logic                          out_neg_re,
   output logic                          out_neg_im,
   output logic [2*DW:0]                 out_mag_re,
   output logic [2*DW:0]                 out_mag_im,
   output logic [2*DW:0]                 out_den
);

   localparam int MW = 2 * DW + 1;
   localparam int SW = 2 * DW + 2;

   cau_pkg::ctrl_type  ctrl_ff;
   logic               neg_re_ff, neg_im_ff, neg_re_in, neg_im_in;
   logic [MW-1:0]      mag_re_ff, mag_im_ff, mag_re_in, mag_im_in;
   logic [MW-1:0]      den_ff, den_in;
   logic signed [SW-1:0] v_re, v_im, abs_re, abs_im, den_s;

   always_comb begin
      v_re   = '0;
      v_im   = '0;
      den_in = '1;
      den_s  = SW'(in_p_bb_r) + SW'(in_p_bb_i);
      case (in_cmd)
         cau_pkg::CMD_ADD: begin
            v_re = SW'(in_a_re) + SW'(in_b_re);
            v_im = SW'(in_a_im) + SW'(in_b_im);
         end
         cau_pkg::CMD_SUB: begin
            v_re = SW'(in_a_re) - SW'(in_b_re);
            v_im = SW'(in_a_im) - SW'(in_b_im);
         end
         cau_pkg::CMD_MUL: begin
            v_re = SW'(in_p_rr) - SW'(in_p_ii);
            v_im = SW'(in_p_ri) + SW'(in_p_ir);
         end
         cau_pkg::CMD_DIV: begin
            if (!in_ctrl.dz) begin
               v_re   = SW'(in_p_rr) + SW'(in_p_ii);
               v_im   = SW'(in_p_ir) - SW'(in_p_ri);
               den_in = den_s[MW-1:0];
            end
         end
         cau_pkg::CMD_CONJ: begin
            v_re = SW'(in_a_re);
            v_im = -SW'(in_a_im);
         end
         default: begin
            v_re = '0;
            v_im = '0;
         end
      endcase
      neg_re_in = v_re[SW-1];
      neg_im_in = v_im[SW-1];
      abs_re    = neg_re_in ? -v_re : v_re;
      abs_im    = neg_im_in ? -v_im : v_im;
      mag_re_in = abs_re[MW-1:0];
      mag_im_in = abs_im[MW-1:0];
      if (in_cmd == cau_pkg::CMD_MUL) begin
         mag_re_in = mag_re_in >> F;
         mag_im_in = mag_im_in >> F;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff.valid <= 1'b0;
      end else begin
         ctrl_ff.valid <= in_ctrl.valid;
      end
      ctrl_ff.is_div <= in_ctrl.is_div;
      ctrl_ff.dz     <= in_ctrl.dz;
      ctrl_ff.eq     <= in_ctrl.eq;
      neg_re_ff      <= neg_re_in;
      neg_im_ff      <= neg_im_in;
      mag_re_ff      <= mag_re_in;
      mag_im_ff      <= mag_im_in;
      den_ff         <= den_in;
   end

   assign out_ctrl   = ctrl_ff;
   assign out_neg_re = neg_re_ff;
   assign out_neg_im = neg_im_ff;
   assign out_mag_re = mag_re_ff;
   assign out_mag_im = mag_im_ff;
   assign out_den    = den_ff;

endmodule

>>> src/cau_div_step.sv
module cau_div_step #(
   parameter int DW  = cau_pkg::DATA_WIDTH,
   parameter int F   = cau_pkg::FRAC_BITS,
   parameter int BIT = 0
) (
   input  logic                 clock,
   input  logic                 reset,
   input  cau_pkg::ctrl_type    in_ctrl,
   input  logic                 in_neg_re,
   input  logic                 in_neg_im,
   input  logic                 in_ovf_re,
   input  logic                 in_ovf_im,
   input  logic [2*DW:0]        in_den,
   input  logic [2*DW+F:0]      in_rem_re,
   input  logic [2*DW+F:0]      in_rem_im,
   input  logic [DW-1:0]        in_q_re,
   input  logic [DW-1:0]        in_q_im,
   output cau_pkg::ctrl_type    out_ctrl,
   output logic                 out_neg_re,
   output logic                 out_neg_im,
   output logic                 out_ovf_re,
   output logic                 out_ovf_im,
   output logic [2*DW:0]        out_den,
   output logic [2*DW+F:0]      out_rem_re,
   output logic [2*DW+F:0]      out_rem_im,
   output logic [DW-1:0]        out_q_re,
   output logic [DW-1:0]        out_q_im
);

   localparam int MW = 2 * DW + 1;
   localparam int NW = MW + F;
   localparam int WW = MW + F + DW;

   cau_pkg::ctrl_type ctrl_ff;
   logic              neg_re_ff, neg_im_ff, ovf_re_ff, ovf_im_ff;
   logic [MW-1:0]     den_ff;
   logic [NW-1:0]     rem_re_ff, rem_im_ff, rem_re_in, rem_im_in;
   logic [DW-1:0]     q_re_ff, q_im_ff, q_re_in, q_im_in;
   logic [WW-1:0]     dsh, ext_re, ext_im;

   always_comb begin
      dsh       = WW'(in_den) << BIT;
      ext_re    = WW'(in_rem_re);
      ext_im    = WW'(in_rem_im);
      rem_re_in = in_rem_re;
      rem_im_in = in_rem_im;
      q_re_in   = in_q_re;
      q_im_in   = in_q_im;
      if (ext_re >= dsh) begin
         rem_re_in = NW'(ext_re - dsh);
         q_re_in   = in_q_re | (DW'(1) << BIT);
      end
      if (ext_im >= dsh) begin
         rem_im_in = NW'(ext_im - dsh);
         q_im_in   = in_q_im | (DW'(1) << BIT);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff.valid <= 1'b0;
      end else begin
         ctrl_ff.valid <= in_ctrl.valid;
      end
      ctrl_ff.is_div <= in_ctrl.is_div;
      ctrl_ff.dz     <= in_ctrl.dz;
      ctrl_ff.eq     <= in_ctrl.eq;
      neg_re_ff      <= in_neg_re;
      neg_im_ff      <= in_neg_im;
      ovf_re_ff      <= in_ovf_re;
      ovf_im_ff      <= in_ovf_im;
      den_ff         <= in_den;
      rem_re_ff      <= rem_re_in;
      rem_im_ff      <= rem_im_in;
      q_re_ff        <= q_re_in;
      q_im_ff        <= q_im_in;
   end

   assign out_ctrl   = ctrl_ff;
   assign out_neg_re = neg_re_ff;
   assign out_neg_im = neg_im_ff;
   assign out_ovf_re = ovf_re_ff;
   assign out_ovf_im = ovf_im_ff;
   assign out_den    = den_ff;
   assign out_rem_re = rem_re_ff;
   assign out_rem_im = rem_im_ff;
   assign out_q_re   = q_re_ff;
   assign out_q_im   = q_im_ff;

endmodule

>>> src/cau_sat.sv
module cau_sat #(
   parameter int DW = cau_pkg::DATA_WIDTH,
   parameter int F  = cau_pkg::FRAC_BITS
) (
   input  logic                 clock,
   input  logic                 reset,
   input  cau_pkg::ctrl_type    in_ctrl,
   input  logic                 in_neg_re,
   input  logic                 in_neg_im,
   input  logic                 in_ovf_re,
   input  logic                 in_ovf_im,
   input  logic [2*DW+F:0]      in_rem_re,
   input  logic [2*DW+F:0]      in_rem_im,
   input  logic [DW-1:0]        in_q_re,
   input  logic [DW-1:0]        in_q_im,
   output logic                 out_valid,
   output logic signed [DW-1:0] out_res_re,
   output logic signed [DW-1:0] out_res_im,
   output logic                 out_is_equal,
   output logic                 out_div_zero,
   output logic                 out_sat_flag
);

   localparam int MW = 2 * DW + 1;

   function automatic logic [DW:0] clip(input logic neg, input logic ovf,
                                        input logic [MW-1:0] mag);
      logic          n;
      logic          s;
      logic [MW-1:0] lim;
      logic [MW-1:0] m;
      n   = neg && (ovf || (mag != '0));
      lim = n ? (MW'(1) << (DW - 1)) : ((MW'(1) << (DW - 1)) - MW'(1));
      s   = ovf || (mag > lim);
      m   = s ? lim : mag;
      m   = n ? (~m + MW'(1)) : m;
      return {s, m[DW-1:0]};
   endfunction

   logic                 use_q;
   logic [MW-1:0]        mag_re, mag_im;
   logic [DW:0]          clip_re, clip_im;
   logic                 valid_ff, is_equal_ff, div_zero_ff, sat_flag_ff;
   logic signed [DW-1:0] res_re_ff, res_im_ff;

   always_comb begin
      use_q   = in_ctrl.is_div && !in_ctrl.dz;
      mag_re  = use_q ? MW'(in_q_re) : in_rem_re[MW-1:0];
      mag_im  = use_q ? MW'(in_q_im) : in_rem_im[MW-1:0];
      clip_re = clip(in_neg_re, use_q && in_ovf_re, mag_re);
      clip_im = clip(in_neg_im, use_q && in_ovf_im, mag_im);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= 1'b0;
         is_equal_ff <= 1'b0;
         div_zero_ff <= 1'b0;
         sat_flag_ff <= 1'b0;
      end else begin
         valid_ff    <= in_ctrl.valid;
         is_equal_ff <= in_ctrl.valid && in_ctrl.eq;
         div_zero_ff <= in_ctrl.valid && in_ctrl.dz;
         sat_flag_ff <= in_ctrl.valid && (clip_re[DW] || clip_im[DW]);
      end
      res_re_ff <= clip_re[DW-1:0];
      res_im_ff <= clip_im[DW-1:0];
   end

   assign out_valid    = valid_ff;
   assign out_res_re   = res_re_ff;
   assign out_res_im   = res_im_ff;
   assign out_is_equal = is_equal_ff;
   assign out_div_zero = div_zero_ff;
   assign out_sat_flag = sat_flag_ff;

endmodule
